// ===== rtl/lnqm_pkg.sv =====
// Shared types and constants for the linked node queue manager.
`timescale 1ns / 1ps
package lnqm_pkg;

	localparam int NUM_NODES_DEF  = 64;
	localparam int NUM_QUEUES_DEF = 4;

	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;

	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_LINKED     = 2'd1;
	localparam logic [1:0] STAT_EMPTY      = 2'd2;
	localparam logic [1:0] STAT_NOT_MEMBER = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] queue_id;
		logic [5:0] node_index;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] queue_length;
		logic [5:0] head_node;
		logic       head_valid;
	} result_t;

	typedef enum logic [2:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_EVAL,
		FSM_LINK,
		FSM_DONE
	} fsm_t;

endpackage

// ===== rtl/lnqm_ram.sv =====
// Single-port-write, registered-read synchronous memory.
`timescale 1ns / 1ps
module lnqm_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/linked_node_queue_manager_core.sv =====
// Top level of the circular doubly linked queue manager over a shared node pool.
// A result passes through the evaluation state, then a link state for an append to a
// non-empty queue, which needs a second write on the link memories, then the completion
// state. A new transaction is accepted only when idle, or in completion with the output free.
// After reset a clearing pass marks every node free; input stalls during the pass.
`timescale 1ns / 1ps
module linked_node_queue_manager_core
	import lnqm_pkg::*;
#(
	parameter int NUM_NODES  = NUM_NODES_DEF,
	parameter int NUM_QUEUES = NUM_QUEUES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int NW = $clog2(NUM_NODES);
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int CW = $clog2(NUM_NODES + 1);
	localparam int XW = (NW > 6) ? NW : 6;
	localparam int QX = (QW > 2) ? QW : 2;
	localparam int SW = QW + 1;

	fsm_t state_q, state_d;

	logic [NW-1:0] clr_q;

	logic [NW-1:0] head_q     [NUM_QUEUES];
	logic [CW-1:0] count_q    [NUM_QUEUES];
	logic          nonempty_q [NUM_QUEUES];

	logic [XW-1:0] node_ext;
	logic [QX-1:0] queue_ext;
	logic [NW-1:0] node_addr;
	logic [QW-1:0] queue_addr;
	logic          node_ok, queue_ok, accept, out_free;

	logic [1:0]    action_s1;
	logic [QW-1:0] q_s1;
	logic [NW-1:0] n_s1, head_s1;
	logic [CW-1:0] cnt_s1;
	logic          q_ok_s1, n_ok_s1, ne_s1;

	logic [SW-1:0] stat_rd;
	logic [NW-1:0] next_rd, prev_rd, tail_rd;
	logic          linked_rd;
	logic [QW-1:0] owner_rd;

	logic          app_ok, rem_empty, rem_ok, single, link_need;
	logic [1:0]    status_d;
	logic          new_ne;
	logic [NW-1:0] new_head;
	logic [CW-1:0] new_cnt;

	logic [1:0]    res_status_q;
	logic [CW-1:0] res_cnt_q;
	logic [NW-1:0] res_head_q;
	logic          res_ne_q, res_valid_q, load_res;

	logic          next_we, prev_we, stat_we;
	logic [NW-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata, stat_waddr;
	logic [SW-1:0] stat_wdata;

	assign node_ext   = XW'(item.node_index);
	assign queue_ext  = QX'(item.queue_id);
	assign node_addr  = node_ext[NW-1:0];
	assign queue_addr = queue_ext[QW-1:0];
	assign node_ok    = 32'(item.node_index) < NUM_NODES;
	assign queue_ok   = 32'(item.queue_id) < NUM_QUEUES;

	assign out_free = !res_valid_q || !result_stall;
	assign accept   = item_valid && !item_stall;

	lnqm_ram #(.DEPTH(NUM_NODES), .WIDTH(SW)) u_stat_ram (
		.clk(clk), .we(stat_we), .waddr(stat_waddr), .wdata(stat_wdata),
		.re(accept), .raddr(node_addr), .rdata(stat_rd)
	);

	lnqm_ram #(.DEPTH(NUM_NODES), .WIDTH(NW)) u_next_ram (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
		.re(accept), .raddr(node_addr), .rdata(next_rd)
	);

	lnqm_ram #(.DEPTH(NUM_NODES), .WIDTH(NW)) u_prev_ram (
		.clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
		.re(accept), .raddr(node_addr), .rdata(prev_rd)
	);

	// A copy of the previous-link memory gives the tail lookup its own read port.
	lnqm_ram #(.DEPTH(NUM_NODES), .WIDTH(NW)) u_tail_ram (
		.clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
		.re(accept), .raddr(head_q[queue_addr]), .rdata(tail_rd)
	);

	assign linked_rd = stat_rd[SW-1];
	assign owner_rd  = stat_rd[QW-1:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= item.action;
			q_s1      <= queue_addr;
			n_s1      <= node_addr;
			head_s1   <= head_q[queue_addr];
			cnt_s1    <= count_q[queue_addr];
			q_ok_s1   <= queue_ok;
			n_ok_s1   <= node_ok;
			ne_s1     <= queue_ok && nonempty_q[queue_addr];
		end
	end

	always_comb begin
		app_ok    = (action_s1 == ACT_APPEND) && q_ok_s1 && n_ok_s1 && !linked_rd;
		rem_empty = !q_ok_s1 || !ne_s1;
		rem_ok    = (action_s1 == ACT_REMOVE) && !rem_empty && n_ok_s1 && linked_rd
			&& (owner_rd == q_s1);
		single    = next_rd == n_s1;
		link_need = app_ok && ne_s1;

		if (action_s1 == ACT_APPEND) begin
			status_d = app_ok ? STAT_OK : STAT_LINKED;
		end else if (action_s1 == ACT_REMOVE) begin
			status_d = rem_empty ? STAT_EMPTY : (rem_ok ? STAT_OK : STAT_NOT_MEMBER);
		end else begin
			status_d = STAT_OK;
		end

		new_ne   = ne_s1;
		new_head = head_s1;
		new_cnt  = cnt_s1;
		if (app_ok) begin
			new_ne  = 1'b1;
			new_cnt = cnt_s1 + CW'(1);
			if (!ne_s1) begin
				new_head = n_s1;
			end
		end else if (rem_ok) begin
			if (cnt_s1 != '0) begin
				new_cnt = cnt_s1 - CW'(1);
			end
			if (single) begin
				new_ne   = 1'b0;
				new_head = '0;
			end else if (head_s1 == n_s1) begin
				new_head = next_rd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FSM_CLEAR) begin
				clr_q <= clr_q + NW'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_CLEAR: begin
				if (clr_q == NW'(NUM_NODES - 1)) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				if (accept) begin
					state_d = FSM_EVAL;
				end
			end
			FSM_EVAL: begin
				state_d = link_need ? FSM_LINK : FSM_DONE;
			end
			FSM_LINK: begin
				state_d = FSM_DONE;
			end
			FSM_DONE: begin
				if (out_free) begin
					state_d = accept ? FSM_EVAL : FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		item_stall = 1'b1;
		load_res   = 1'b0;
		next_we    = 1'b0;
		next_waddr = n_s1;
		next_wdata = n_s1;
		prev_we    = 1'b0;
		prev_waddr = n_s1;
		prev_wdata = n_s1;
		stat_we    = 1'b0;
		stat_waddr = n_s1;
		stat_wdata = '0;
		case (state_q)
			FSM_CLEAR: begin
				stat_we    = 1'b1;
				stat_waddr = clr_q;
			end
			FSM_IDLE: begin
				item_stall = 1'b0;
			end
			FSM_EVAL: begin
				if (app_ok) begin
					next_we    = 1'b1;
					next_waddr = ne_s1 ? tail_rd : n_s1;
					prev_we    = 1'b1;
					prev_wdata = ne_s1 ? tail_rd : n_s1;
					stat_we    = 1'b1;
					stat_wdata = {1'b1, q_s1};
				end else if (rem_ok) begin
					next_we    = !single;
					next_waddr = prev_rd;
					next_wdata = next_rd;
					prev_we    = !single;
					prev_waddr = next_rd;
					prev_wdata = prev_rd;
					stat_we    = 1'b1;
					stat_wdata = {1'b0, owner_rd};
				end
			end
			FSM_LINK: begin
				next_we    = 1'b1;
				next_wdata = head_s1;
				prev_we    = 1'b1;
				prev_waddr = head_s1;
			end
			FSM_DONE: begin
				item_stall = !out_free;
				load_res   = out_free;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				nonempty_q[i] <= 1'b0;
				count_q[i]    <= '0;
			end
		end else if (state_q == FSM_EVAL && (app_ok || rem_ok)) begin
			nonempty_q[q_s1] <= new_ne;
			count_q[q_s1]    <= new_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_EVAL && (app_ok || rem_ok)) begin
			head_q[q_s1] <= new_head;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_EVAL) begin
			res_status_q <= status_d;
			res_cnt_q    <= new_cnt;
			res_head_q   <= new_head;
			res_ne_q     <= new_ne;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			result.status       <= res_status_q;
			result.queue_length <= res_ne_q ? 7'(res_cnt_q) : 7'd0;
			result.head_node    <= res_ne_q ? 6'(res_head_q) : 6'd0;
			result.head_valid   <= res_ne_q;
		end
	end

	assign result_valid = res_valid_q;

	logic [NUM_QUEUES-1:0] count_agrees;

	always_comb begin
		for (int i = 0; i < NUM_QUEUES; i++) begin
			count_agrees[i] = nonempty_q[i] == (count_q[i] != '0);
		end
	end

	a_count_matches_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		&count_agrees)
		else $error("Queue count and non-empty flag disagree.");

	a_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == FSM_DONE)
		else $error("Result raised outside the completion state.");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_CLEAR |=> !$past(accept))
		else $error("Transaction accepted during the clearing pass.");

endmodule
